// ===== rtl/tklt_pkg.sv =====
// Shared types and codes for the time-keyed interpolation table.
package tklt_pkg;
	localparam int unsigned VAL_W  = 32;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_DROPPED  = 2'd2,
		ST_REPLACED = 2'd3
	} status_t;

	typedef struct packed {
		logic [VAL_W-1:0] key;
		logic [VAL_W-1:0] irr;
		logic [VAL_W-1:0] azi;
		logic [VAL_W-1:0] zen;
	} entry_t;
endpackage

// ===== rtl/time_keyed_lerp_table.sv =====
// Top level: sorted time-keyed table with insert, clear and interpolating query.
//
//  channel  dir  width  contents
//  s_axis   in   136    tdata: mode[1:0] key_time[33:2] irr[65:34] azi[97:66] zen[129:98]
//  m_axis   out  104    tdata: irr[31:0] azi[63:32] zen[95:64] status[97:96]
//
// After a transfer is taken: clear, mode 3 and an empty query go straight to the output. An
// insert scans for its place, then replaces an equal key or shifts the later entries up and
// writes, or drops when full; a query scans, then clamps to the first or last entry or goes
// through a 48-bit restoring divider (one quotient bit a cycle) and three lerps over one
// shared multiplier. All of it is serial: a single read port on the entry memory and a serial
// divider. Reset clears the state, entry count, position and output valid; the memory is left as is.
// A result waits in the output register; no new transfer is taken until it is taken.
module time_keyed_lerp_table #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // mode, key_time, in_irradiance, in_azimuth, in_zenith
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata   // out_irradiance, out_azimuth, out_zenith, status
);
	import tklt_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR, S_PUT,
		S_LO_RD, S_LO_WAIT, S_DIV, S_MUL, S_OUT
	} state_t;

	entry_t mem [TABLE_DEPTH];
	entry_t rd_q;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;

	state_t state_q;
	logic [CW-1:0] count_q, pos_q;
	mode_t mode_q;
	entry_t in_q, hi_q, lo_q;
	logic [47:0] rem_q;
	logic [47:0] num_q;
	logic [31:0] den_q;
	logic [5:0]  bit_q;
	logic [15:0] a_q;
	logic [1:0]  lane_q;
	logic [1:0]  phase_q;
	logic signed [63:0] acc_q;
	logic [VAL_W-1:0] res_q [3];
	logic [1:0] status_q;
	logic out_valid_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// Shared multiplier operands: left value and 1-a, then right value and a
	logic signed [32:0] m_a;
	logic signed [17:0] m_b;
	logic [VAL_W-1:0] lv, rv;
	always_comb begin
		case (lane_q)
			2'd0: begin lv = lo_q.irr; rv = hi_q.irr; end
			2'd1: begin lv = lo_q.azi; rv = hi_q.azi; end
			default: begin lv = lo_q.zen; rv = hi_q.zen; end
		endcase
		m_a = (phase_q == 2'd1) ? 33'(signed'(rv)) : 33'(signed'(lv));
		m_b = (phase_q == 2'd1) ? signed'({2'b0, a_q}) : signed'(18'h10000 - {2'b0, a_q});
	end

	logic [48:0] trial;
	assign trial = {rem_q, num_q[47]} - {17'd0, den_q};

	always_comb begin
		raddr = pos_q[AW-1:0];
		we = 1'b0;
		waddr = pos_q[AW-1:0];
		wdata = in_q;
		if (state_q == S_SHIFT_WR) begin
			we = 1'b1;
			wdata = rd_q;
		end else if (state_q == S_PUT) begin
			we = 1'b1;
		end else if (state_q == S_SHIFT_RD) begin
			raddr = AW'(pos_q - 1'b1);
		end else if (state_q == S_LO_RD) begin
			raddr = AW'(pos_q - 1'b1);
		end
	end

	assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {6'd0, status_q, res_q[2], res_q[1], res_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
			pos_q <= '0;
		end else begin
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					mode_q <= mode_t'(s_axis_tdata[1:0]);
					in_q.key <= s_axis_tdata[33:2];
					in_q.irr <= s_axis_tdata[65:34];
					in_q.azi <= s_axis_tdata[97:66];
					in_q.zen <= s_axis_tdata[129:98];
					res_q[0] <= '0; res_q[1] <= '0; res_q[2] <= '0;
					status_q <= ST_DONE;
					pos_q <= '0;
					case (mode_t'(s_axis_tdata[1:0]))
						MODE_CLEAR: begin count_q <= '0; state_q <= S_OUT; end
						MODE_INSERT: state_q <= S_SCAN_RD;
						MODE_QUERY: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								state_q <= S_OUT;
							end else state_q <= S_SCAN_RD;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_SCAN_RD: begin
					if (pos_q == count_q) begin
						// Ran off the end
						if (mode_q == MODE_INSERT) begin
							if (count_q == DEPTH_C) begin
								status_q <= ST_DROPPED;
								state_q <= S_OUT;
							end else begin
								pos_q <= count_q;
								state_q <= (count_q == pos_q) ? S_PUT : S_SHIFT_RD;
							end
						end else begin
							// load the last entry; a zero upper key forces the clamp
							hi_q.key <= '0;
							state_q <= S_LO_RD;
						end
					end else state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (mode_q == MODE_INSERT) begin
						if (rd_q.key == in_q.key) begin
							status_q <= ST_REPLACED;
							state_q <= S_PUT;
						end else if (rd_q.key > in_q.key) begin
							if (count_q == DEPTH_C) begin
								status_q <= ST_DROPPED;
								state_q <= S_OUT;
							end else begin
								num_q[CW-1:0] <= pos_q; // hold insert point
								pos_q <= count_q;
								state_q <= S_SHIFT_RD;
							end
						end else begin
							pos_q <= pos_q + 1'b1;
							state_q <= S_SCAN_RD;
						end
					end else begin
						if (in_q.key < rd_q.key || (pos_q == '0 && in_q.key == rd_q.key)) begin
							if (pos_q == '0) begin
								res_q[0] <= rd_q.irr; res_q[1] <= rd_q.azi;
								res_q[2] <= rd_q.zen;
								out_valid_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								hi_q <= rd_q;
								state_q <= S_LO_RD;
							end
						end else begin
							pos_q <= pos_q + 1'b1;
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SHIFT_RD: begin
					if (pos_q == num_q[CW-1:0] || pos_q == '0) begin
						state_q <= S_PUT;
					end else state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					pos_q <= pos_q - 1'b1;
					state_q <= S_SHIFT_RD;
				end
				S_PUT: begin
					if (status_q != ST_REPLACED) count_q <= count_q + 1'b1;
					state_q <= S_OUT;
				end
				S_LO_RD: state_q <= S_LO_WAIT;
				S_LO_WAIT: begin
					if (in_q.key >= hi_q.key || hi_q.key <= rd_q.key) begin
						// last-entry clamp path
						res_q[0] <= rd_q.irr; res_q[1] <= rd_q.azi; res_q[2] <= rd_q.zen;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						lo_q <= rd_q;
						num_q <= {in_q.key - rd_q.key, 16'd0};
						den_q <= hi_q.key - rd_q.key;
						rem_q <= '0;
						bit_q <= 6'd48;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (trial[48]) rem_q <= {rem_q[46:0], num_q[47]};
					else rem_q <= trial[47:0];
					num_q <= {num_q[46:0], ~trial[48]};
					bit_q <= bit_q - 1'b1;
					if (bit_q == 6'd1) begin
						lane_q <= '0;
						phase_q <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (phase_q == 2'd0) begin
						a_q <= (num_q[47:16] != '0) ? 16'hFFFF : num_q[15:0];
						acc_q <= 64'sd32768;
						phase_q <= 2'd3;
					end else if (phase_q == 2'd3) begin
						acc_q <= acc_q + 64'(m_a * m_b);
						phase_q <= 2'd1;
					end else if (phase_q == 2'd1) begin
						acc_q <= acc_q + 64'(m_a * m_b);
						phase_q <= 2'd2;
					end else begin
						res_q[lane_q] <= acc_q[47:16];
						acc_q <= 64'sd32768;
						if (lane_q == 2'd2) begin
							out_valid_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							lane_q <= lane_q + 1'b1;
							phase_q <= 2'd3;
						end
					end
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/tklt_checker.sv =====
// Port-level checks for the interpolation table, bound to the top level.
module tklt_props (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata
);
	import tklt_pkg::*;

	// One item in flight: no new transfer while a result is pending.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[97:96] == ST_EMPTY |-> m_axis_tdata[95:0] == '0)
		else $error("empty query with nonzero values");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready right after accept");
endmodule

bind time_keyed_lerp_table tklt_props u_tklt_props (.*);

// ===== test/tklt_checker.sv =====
// Checker for the time-keyed interpolation table: watches both channels, predicts, compares.
`timescale 1ns / 100ps
module tklt_checker #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // mode, key_time, in_irradiance, in_azimuth, in_zenith
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [103:0] m_axis_tdata,  // out_irradiance, out_azimuth, out_zenith, status
	output int           fail_count,
	output int           pending,
	output int           lookups_seen,
	output int           results_seen
);
	import tklt_pkg::*;

	typedef struct packed {
		logic [31:0] irr;
		logic [31:0] azi;
		logic [31:0] zen;
		status_t     status;
	} answer_t;

	logic [31:0] tbl_key [TABLE_DEPTH];
	logic [31:0] tbl_irr [TABLE_DEPTH];
	logic [31:0] tbl_azi [TABLE_DEPTH];
	logic [31:0] tbl_zen [TABLE_DEPTH];
	int unsigned tbl_fill;
	answer_t     answers[$];

	function automatic logic [31:0] blend(logic [31:0] lv, logic [31:0] rv, logic [16:0] w);
		logic signed [65:0] acc;
		acc = $signed({{34{lv[31]}}, lv}) * $signed({49'd0, 17'h10000 - w})
			+ $signed({{34{rv[31]}}, rv}) * $signed({49'd0, w}) + 66'sd32768;
		return acc[47:16];
	endfunction

	task automatic apply_transfer(logic [135:0] d);
		mode_t       md;
		logic [31:0] t, vi, va, vz, lo, den;
		logic [47:0] wide;
		logic [16:0] w;
		answer_t     ans;
		int unsigned pos, j;
		bit          hit;
		md = mode_t'(d[1:0]);
		t = d[33:2];
		vi = d[65:34];
		va = d[97:66];
		vz = d[129:98];
		ans = '0;
		ans.status = ST_DONE;
		case (md)
			MODE_CLEAR: tbl_fill = 0;
			MODE_INSERT: begin
				pos = 0;
				while (pos < tbl_fill && tbl_key[pos] < t) pos++;
				if (pos < tbl_fill && tbl_key[pos] == t) begin
					tbl_irr[pos] = vi; tbl_azi[pos] = va; tbl_zen[pos] = vz;
					ans.status = ST_REPLACED;
				end else if (tbl_fill >= TABLE_DEPTH) begin
					ans.status = ST_DROPPED;
				end else begin
					for (j = tbl_fill; j > pos; j--) begin
						tbl_key[j] = tbl_key[j-1]; tbl_irr[j] = tbl_irr[j-1];
						tbl_azi[j] = tbl_azi[j-1]; tbl_zen[j] = tbl_zen[j-1];
					end
					tbl_key[pos] = t; tbl_irr[pos] = vi; tbl_azi[pos] = va; tbl_zen[pos] = vz;
					tbl_fill++;
				end
			end
			MODE_QUERY: begin
				lookups_seen++;
				if (tbl_fill == 0) begin
					ans.status = ST_EMPTY;
				end else if (t <= tbl_key[0]) begin
					ans.irr = tbl_irr[0]; ans.azi = tbl_azi[0]; ans.zen = tbl_zen[0];
				end else begin
					hit = 0;
					for (j = 1; j < tbl_fill && !hit; j++) begin
						if (t < tbl_key[j]) begin
							lo = tbl_key[j-1];
							den = tbl_key[j] - lo;
							wide = {t - lo, 16'd0} / {16'd0, den};
							w = (wide > 48'hFFFF) ? 17'hFFFF : {1'b0, wide[15:0]};
							ans.irr = blend(tbl_irr[j-1], tbl_irr[j], w);
							ans.azi = blend(tbl_azi[j-1], tbl_azi[j], w);
							ans.zen = blend(tbl_zen[j-1], tbl_zen[j], w);
							hit = 1;
						end
					end
					if (!hit) begin
						ans.irr = tbl_irr[tbl_fill-1];
						ans.azi = tbl_azi[tbl_fill-1];
						ans.zen = tbl_zen[tbl_fill-1];
					end
				end
			end
			default: ;
		endcase
		answers.push_back(ans);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		lookups_seen = 0;
		results_seen = 0;
		tbl_fill = 0;
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (answers.size() == 0) begin
					report_mismatch("unexpected transfer", m_axis_tdata[31:0], 0);
				end else begin
					want = answers.pop_front();
					if (m_axis_tdata[31:0] !== want.irr)
						report_mismatch("irradiance", m_axis_tdata[31:0], want.irr);
					if (m_axis_tdata[63:32] !== want.azi)
						report_mismatch("azimuth", m_axis_tdata[63:32], want.azi);
					if (m_axis_tdata[95:64] !== want.zen)
						report_mismatch("zenith", m_axis_tdata[95:64], want.zen);
					if (m_axis_tdata[97:96] !== want.status)
						report_mismatch("status", m_axis_tdata[97:96], want.status);
				end
			end
			// predict after popping so a same-edge result matches the older entry
			if (s_axis_tvalid && s_axis_tready)
				apply_transfer(s_axis_tdata);
			pending = answers.size();
		end
	end
endmodule

// ===== test/tb_top.sv =====
// Testbench top: clock, reset, stimulus and verdict for the interpolation table.
`timescale 1ns / 100ps
module tb_top;
	import tklt_pkg::*;

	localparam int unsigned DEPTH = 64;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;  // mode, key_time, in_irradiance, in_azimuth, in_zenith
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [103:0] m_axis_tdata;       // out_irradiance, out_azimuth, out_zenith, status
	int           fail_count, pending, lookups_seen, results_seen;
	logic [31:0]  used_keys[$];

	always #5 clk = ~clk;

	time_keyed_lerp_table #(.TABLE_DEPTH(DEPTH)) u_dut (.*);

	tklt_checker #(.TABLE_DEPTH(DEPTH)) u_chk (.*);

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_key();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return (used_keys.size() > 0)
				? used_keys[$urandom_range(0, used_keys.size() - 1)] : 32'h0;
			3: return $urandom_range(0, 200);
			default: return $urandom;
		endcase
	endfunction

	// hand one transfer to the block, with a random gap between bursts
	task automatic send(mode_t md, logic [31:0] k, logic [31:0] vi, logic [31:0] va,
			logic [31:0] vz);
		s_axis_tdata <= {6'd0, vz, va, vi, k, md};
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
		if (md == MODE_INSERT) used_keys.push_back(k);
		if (used_keys.size() > 256) void'(used_keys.pop_front());
		if ($urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	task automatic send_rand(mode_t md);
		send(md, rand_key(), rand_value(), rand_value(), rand_value());
	endtask

	// receiver stall pattern: stretches of always-ready and of random stalls
	initial begin
		int mode_len;
		forever begin
			mode_len = $urandom_range(20, 300);
			if ($urandom_range(0, 2) == 0) begin
				repeat (mode_len) @(posedge clk) m_axis_tready <= 1;
			end else begin
				repeat (mode_len) @(posedge clk) m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	initial begin
		int k, r;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty query, extremes, clamps, inner key, replace, mode 3, clear
		send(MODE_QUERY, 32'h1000, 0, 0, 0);
		send(MODE_INSERT, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		send(MODE_INSERT, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send(MODE_INSERT, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
		send(MODE_QUERY, 32'h0, 0, 0, 0);
		send(MODE_QUERY, 32'h0001_0000, 0, 0, 0);
		send(MODE_QUERY, 32'h0001_8000, 0, 0, 0);
		send(MODE_QUERY, 32'h0002_0000, 0, 0, 0);
		send(MODE_QUERY, 32'h0002_FFFF, 0, 0, 0);
		send(MODE_QUERY, 32'hFFFF_FFFF, 0, 0, 0);
		send(MODE_INSERT, 32'h0002_0000, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF);
		send(MODE_QUERY, 32'h0002_4000, 0, 0, 0);
		send(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(MODE_INSERT, 32'h0, 32'h5, 32'h6, 32'h7);
		send(MODE_INSERT, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
		send(MODE_QUERY, 32'hFFFF_FFFE, 0, 0, 0);
		send(MODE_CLEAR, 32'hFFFF_FFFF, 0, 0, 0);
		send(MODE_QUERY, 32'h5, 0, 0, 0);
		// fill past capacity: drops, then replace on a full table
		for (k = 0; k < DEPTH + 3; k++)
			send(MODE_INSERT, k * 32'h0001_0000 + 7, rand_value(), rand_value(), rand_value());
		send(MODE_INSERT, 32'd7, 32'h1, 32'h2, 32'h3);
		send(MODE_QUERY, 32'h0200_0000, 0, 0, 0);
		send(MODE_CLEAR, 0, 0, 0, 0);
		// random: fill-and-query sessions with occasional clears and noise
		k = 0;
		while (k < 1250) begin
			r = $urandom_range(0, 99);
			if (r < 2) send_rand(MODE_CLEAR);
			else if (r < 4) send_rand(MODE_NONE);
			else if (r < 50) send_rand(MODE_INSERT);
			else send_rand(MODE_QUERY);
			k++;
		end
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Covered %0d results, %0d lookups, inserts up to full table and replaces.",
			results_seen, lookups_seen);
		if (fail_count == 0)
			$display("[time_keyed_lerp_table] OK");
		else
			$display("[time_keyed_lerp_table] ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("[time_keyed_lerp_table] ERROR");
		$finish;
	end
endmodule
